@@ design/msgfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msgfe_pkg
// Shared types, constants and helpers of the mass-spring grid force evaluator.
// ----------------------------------------------------------------------------
package msgfe_pkg;

    localparam int MAX_PARTICLES_DEF = 1024;
    localparam int COORD_WIDTH_DEF   = 32;

    localparam int DATA_W  = 32;   // stored coordinate width
    localparam int PART_W  = 10;   // particle index width
    localparam int ACC_W   = 48;   // force accumulator width
    localparam int LEN_W   = 32;   // spring length width
    localparam int QUOT_W  = 17;   // unit component magnitude width
    localparam int REST_W  = 22;   // rest length / home spacing width
    localparam int CNT_W   = 5;    // iteration counter width
    localparam int NUM_NB  = 12;
    localparam int QDEPTH  = 2;

    localparam logic [16:0] SQRT2_Q16      = 17'd92682;
    localparam logic [16:0] HOME_SCALE_Q16 = 17'd67502;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        K_STRUCT = 2'd0,
        K_SHEAR  = 2'd1,
        K_FLEX   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        R_GRID_ROWS    = 3'd0,
        R_GRID_COLUMNS = 3'd1,
        R_INVERSE_MASS = 3'd2,
        R_ANCHOR       = 3'd3,
        R_STIFFNESS    = 3'd4,
        R_DRAG         = 3'd5,
        R_ANCHOR_GAIN  = 3'd6,
        R_REST_LENGTH  = 3'd7
    } t_reg;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SELF, ST_ROWCOL, ST_DRAG, ST_NB, ST_NB_RD, ST_DIFF, ST_SQ,
        ST_ROOT, ST_ROOT_WAIT, ST_TENS, ST_UNIT, ST_ACC, ST_HOME, ST_ANCHOR, ST_FIN
    } t_state;

    typedef struct packed {
        t_op                      op;
        logic [PART_W-1:0]        particle;
        logic [2:0][DATA_W-1:0]   pos;
        logic [2:0][DATA_W-1:0]   vel;
    } t_item;

    typedef struct packed {
        logic [10:0] rows;
        logic [10:0] cols;
        logic [24:0] inv_mass;
        logic [9:0]  anchor;
        logic [24:0] stiffness;
        logic [20:0] drag;
        logic [20:0] gain;
        logic [20:0] rest;
    } t_cfg;

    typedef struct packed {
        logic signed [2:0] dr;
        logic signed [2:0] dc;
        t_kind             kind;
    } t_nbr;

    function automatic t_nbr nb_lookup(input logic [3:0] idx);
        t_nbr n;
        unique case (idx)
            4'd0:    n = '{dr:  3'sd1, dc:  3'sd0, kind: K_STRUCT};
            4'd1:    n = '{dr: -3'sd1, dc:  3'sd0, kind: K_STRUCT};
            4'd2:    n = '{dr:  3'sd0, dc:  3'sd1, kind: K_STRUCT};
            4'd3:    n = '{dr:  3'sd0, dc: -3'sd1, kind: K_STRUCT};
            4'd4:    n = '{dr:  3'sd1, dc:  3'sd1, kind: K_SHEAR};
            4'd5:    n = '{dr: -3'sd1, dc: -3'sd1, kind: K_SHEAR};
            4'd6:    n = '{dr:  3'sd1, dc: -3'sd1, kind: K_SHEAR};
            4'd7:    n = '{dr: -3'sd1, dc:  3'sd1, kind: K_SHEAR};
            4'd8:    n = '{dr:  3'sd2, dc:  3'sd0, kind: K_FLEX};
            4'd9:    n = '{dr: -3'sd2, dc:  3'sd0, kind: K_FLEX};
            4'd10:   n = '{dr:  3'sd0, dc:  3'sd2, kind: K_FLEX};
            4'd11:   n = '{dr:  3'sd0, dc: -3'sd2, kind: K_FLEX};
            default: n = '{dr:  3'sd0, dc:  3'sd0, kind: K_STRUCT};
        endcase
        return n;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sd2147483647);
        lo = ACC_W'(-64'sd2147483648);
        if (v > hi) begin
            return DATA_W'(hi);
        end else if (v < lo) begin
            return DATA_W'(lo);
        end
        return DATA_W'(v);
    endfunction

endpackage

@@ design/msgfe_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msgfe_front
// Input side: takes items, tags them as load or evaluate and queues them.
// ----------------------------------------------------------------------------
module msgfe_front import msgfe_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_op,
    input  logic [PART_W-1:0]        i_particle,
    input  logic signed [DATA_W-1:0] i_pos_x,
    input  logic signed [DATA_W-1:0] i_pos_y,
    input  logic signed [DATA_W-1:0] i_pos_z,
    input  logic signed [DATA_W-1:0] i_vel_x,
    input  logic signed [DATA_W-1:0] i_vel_y,
    input  logic signed [DATA_W-1:0] i_vel_z,
    output logic                     o_q_valid,
    output t_item                    o_q_item,
    input  logic                     i_q_pop
);

    localparam int PTR_W = $clog2(QDEPTH);

    t_item             r_mem [QDEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W:0]    r_count;
    logic              push;
    logic              pop;
    t_item             item;

    assign o_in_stall = (r_count == (PTR_W+1)'(QDEPTH));
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_mem[r_rd_ptr];
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_q_pop && o_q_valid;

    always_comb begin
        item.op       = (i_op == 1'b1) ? OP_EVAL : OP_LOAD;
        item.particle = i_particle;
        item.pos      = {i_pos_z, i_pos_y, i_pos_x};
        item.vel      = {i_vel_z, i_vel_y, i_vel_x};
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ design/msgfe_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msgfe_div
// Restoring divider, one quotient bit per cycle, with a preloaded remainder.
// ----------------------------------------------------------------------------
module msgfe_div import msgfe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [LEN_W-1:0]  i_rem0,
    input  logic [QUOT_W-1:0] i_num,
    input  logic [LEN_W-1:0]  i_den,
    input  logic [CNT_W-1:0]  i_steps,
    output logic              o_busy,
    output logic [QUOT_W-1:0] o_quot,
    output logic [LEN_W-1:0]  o_rem
);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [LEN_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_num;
    logic [QUOT_W-1:0] r_quot;
    logic [LEN_W-1:0]  r_den;
    logic [LEN_W:0]    trial;
    logic              ge;

    assign trial  = {r_rem, r_num[QUOT_W-1]};
    assign ge     = (trial >= {1'b0, r_den});
    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_rem0;
            r_num  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? LEN_W'(trial - {1'b0, r_den}) : trial[LEN_W-1:0];
            r_num  <= {r_num[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], ge};
        end
    end

endmodule

@@ design/msgfe_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msgfe_sqrt
// Integer square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module msgfe_sqrt import msgfe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [2*LEN_W-1:0] i_val,
    output logic               o_busy,
    output logic [LEN_W-1:0]   o_root
);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [2*LEN_W-1:0] r_val;
    logic [LEN_W+1:0]   r_rem;
    logic [LEN_W-1:0]   r_root;
    logic [LEN_W+1:0]   rem2;
    logic [LEN_W+1:0]   trial;
    logic               ge;

    // remainder stays below 2^32 before each shift
    assign rem2   = {r_rem[LEN_W-1:0], r_val[2*LEN_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign ge     = (rem2 >= trial);
    assign o_busy = r_busy;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(LEN_W-1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[2*LEN_W-3:0], 2'b00};
            r_rem  <= ge ? (rem2 - trial) : rem2;
            r_root <= {r_root[LEN_W-2:0], ge};
        end
    end

endmodule

@@ design/msgfe_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msgfe_back
// Execution side: particle stores, force sequencer and result register.
// ----------------------------------------------------------------------------
module msgfe_back import msgfe_pkg::*; #(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_q_valid,
    input  t_item                    i_q_item,
    output logic                     o_q_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [PART_W-1:0]        o_particle_out,
    output logic signed [DATA_W-1:0] o_dpos_x,
    output logic signed [DATA_W-1:0] o_dpos_y,
    output logic signed [DATA_W-1:0] o_dpos_z,
    output logic signed [DATA_W-1:0] o_dvel_x,
    output logic signed [DATA_W-1:0] o_dvel_y,
    output logic signed [DATA_W-1:0] o_dvel_z,
    output logic                     o_degenerate
);

    localparam int AW = $clog2(MAX_PARTICLES);
    localparam logic signed [63:0] CW_MAX = (64'sd1 <<< (COORD_WIDTH-1)) - 64'sd1;
    localparam logic signed [63:0] CW_MIN = -CW_MAX - 64'sd1;

    // particle stores
    logic [3*DATA_W-1:0] r_pos_mem [MAX_PARTICLES];
    logic [3*DATA_W-1:0] r_vel_mem [MAX_PARTICLES];
    logic [3*DATA_W-1:0] r_rd_pos;
    logic [3*DATA_W-1:0] r_rd_vel;

    t_state                   r_state;
    t_state                   n_state;
    logic [PART_W-1:0]        r_p;
    logic signed [DATA_W-1:0] r_pos [3];
    logic signed [DATA_W-1:0] r_vel [3];
    logic [PART_W-1:0]        r_row;
    logic [PART_W-1:0]        r_col;
    logic [3:0]               r_nb;
    logic [1:0]               r_k;
    logic signed [ACC_W-1:0]  r_acc [3];
    logic                     r_degen;
    logic [AW-1:0]            r_naddr;
    logic signed [DATA_W-1:0] r_d [3];
    logic [2*LEN_W-1:0]       r_sum;
    logic [LEN_W-1:0]         r_len;
    logic signed [43:0]       r_tens;
    logic [REST_W-1:0]        r_rest_shear;
    logic [REST_W-1:0]        r_spacing;
    logic [DATA_W-1:0]        r_home_x;
    logic [DATA_W-1:0]        r_home_z;

    logic                     r_out_valid;
    logic [PART_W-1:0]        r_out_p;
    logic signed [DATA_W-1:0] r_out_dpos [3];
    logic signed [DATA_W-1:0] r_out_dvel [3];
    logic                     r_out_degen;

    // control
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_addr;
    logic              div_start;
    logic              rc_start;
    logic              sqrt_start;
    logic              out_load;
    logic              slot_free;
    logic              last_nb;

    logic [10:0]       rows_eff;
    logic [10:0]       cols_eff;
    t_nbr              nbr;
    logic signed [11:0] nr;
    logic signed [11:0] nc;
    logic              inb;
    logic [22:0]       lin;

    logic [LEN_W-1:0]  div_rem0  [3];
    logic [QUOT_W-1:0] div_num   [3];
    logic [LEN_W-1:0]  div_den   [3];
    logic [CNT_W-1:0]  div_steps [3];
    logic              div_go    [3];
    logic              div_busy  [3];
    logic [QUOT_W-1:0] div_quot  [3];
    logic [LEN_W-1:0]  div_rem   [3];
    logic [DATA_W-1:0] mag       [3];
    logic              sqrt_busy;
    logic [LEN_W-1:0]  sqrt_root;
    logic [REST_W-1:0] rest_sel;

    assign rows_eff  = (i_cfg.rows == '0) ? 11'd1 : i_cfg.rows;
    assign cols_eff  = (i_cfg.cols == '0) ? 11'd1 : i_cfg.cols;
    assign nbr       = nb_lookup(r_nb);
    assign nr        = $signed({2'b00, r_row}) + 12'(nbr.dr);
    assign nc        = $signed({2'b00, r_col}) + 12'(nbr.dc);
    assign inb       = (nr >= 0) && (nr < $signed({1'b0, rows_eff}))
                    && (nc >= 0) && (nc < $signed({1'b0, cols_eff}));
    assign lin       = 23'(nr[10:0]) * 23'(cols_eff) + 23'(nc[10:0]);
    assign slot_free = !r_out_valid || !i_out_stall;
    assign last_nb   = (r_nb == 4'(NUM_NB-1));

    always_comb begin
        unique case (nbr.kind)
            K_STRUCT: rest_sel = {1'b0, i_cfg.rest};
            K_SHEAR:  rest_sel = r_rest_shear;
            K_FLEX:   rest_sel = {i_cfg.rest, 1'b0};
            default:  rest_sel = {1'b0, i_cfg.rest};
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid && i_q_item.op == OP_EVAL) begin
                    n_state = ST_SELF;
                end
            end
            ST_SELF:   n_state = ST_ROWCOL;
            ST_ROWCOL: begin
                if (!div_busy[0]) begin
                    n_state = ST_DRAG;
                end
            end
            ST_DRAG: begin
                if (r_k == 2'd2) begin
                    n_state = ST_NB;
                end
            end
            ST_NB: begin
                if (inb) begin
                    n_state = ST_NB_RD;
                end else if (last_nb) begin
                    n_state = ST_HOME;
                end
            end
            ST_NB_RD: n_state = ST_DIFF;
            ST_DIFF:  n_state = ST_SQ;
            ST_SQ: begin
                if (r_k == 2'd2) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (r_sum != '0) begin
                    n_state = ST_ROOT_WAIT;
                end else if (last_nb) begin
                    n_state = ST_HOME;
                end else begin
                    n_state = ST_NB;
                end
            end
            ST_ROOT_WAIT: begin
                if (!sqrt_busy) begin
                    n_state = ST_TENS;
                end
            end
            ST_TENS: n_state = ST_UNIT;
            ST_UNIT: begin
                if (!div_busy[0] && !div_busy[1] && !div_busy[2]) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC:    n_state = last_nb ? ST_HOME : ST_NB;
            ST_HOME:   n_state = ST_ANCHOR;
            ST_ANCHOR: n_state = ST_FIN;
            ST_FIN: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = r_naddr;
        o_q_pop    = 1'b0;
        rc_start   = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                mem_addr = AW'(i_q_item.particle);
                o_q_pop  = i_q_valid;
                mem_we   = i_q_valid && (i_q_item.op == OP_LOAD);
                mem_re   = i_q_valid && (i_q_item.op == OP_EVAL);
            end
            ST_SELF:  rc_start   = 1'b1;
            ST_NB_RD: mem_re     = 1'b1;
            ST_ROOT:  sqrt_start = (r_sum != '0);
            ST_TENS:  div_start  = 1'b1;
            ST_FIN:   out_load   = slot_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_pos_mem[mem_addr] <= i_q_item.pos;
            r_vel_mem[mem_addr] <= i_q_item.vel;
        end
        if (mem_re) begin
            r_rd_pos <= r_pos_mem[mem_addr];
            r_rd_vel <= r_vel_mem[mem_addr];
        end
    end

    // divider lanes; lane 0 also splits the index into row and column
    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_div
            assign mag[g] = r_d[g][DATA_W-1] ? DATA_W'(-r_d[g]) : DATA_W'(r_d[g]);
            always_comb begin
                if (g == 0 && r_state == ST_SELF) begin
                    div_rem0[g]  = '0;
                    div_num[g]   = {r_p, 7'b0};
                    div_den[g]   = LEN_W'(cols_eff);
                    div_steps[g] = CNT_W'(PART_W);
                    div_go[g]    = rc_start;
                end else begin
                    div_rem0[g]  = LEN_W'(mag[g] >> 1);
                    div_num[g]   = {mag[g][0], 16'b0};
                    div_den[g]   = r_len;
                    div_steps[g] = CNT_W'(QUOT_W);
                    div_go[g]    = div_start;
                end
            end
            msgfe_div u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_start (div_go[g]),
                .i_rem0  (div_rem0[g]),
                .i_num   (div_num[g]),
                .i_den   (div_den[g]),
                .i_steps (div_steps[g]),
                .o_busy  (div_busy[g]),
                .o_quot  (div_quot[g]),
                .o_rem   (div_rem[g])
            );
        end
    endgenerate

    msgfe_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_val   (r_sum),
        .o_busy  (sqrt_busy),
        .o_root  (sqrt_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        logic signed [53:0] p_drag;
        logic signed [63:0] p_sq;
        logic signed [33:0] stretch;
        logic signed [59:0] p_tens;
        logic signed [17:0] u;
        logic signed [61:0] p_spr;
        logic signed [33:0] hdiff;
        logic signed [55:0] p_anc;
        logic [DATA_W-1:0]  home;
        unique case (r_state)
            ST_IDLE: begin
                r_k <= '0;
                if (i_q_valid) begin
                    r_p <= i_q_item.particle;
                end
            end
            ST_SELF: begin
                for (int k = 0; k < 3; k++) begin
                    r_pos[k] <= $signed(r_rd_pos[k*DATA_W +: DATA_W]);
                    r_vel[k] <= $signed(r_rd_vel[k*DATA_W +: DATA_W]);
                end
                r_rest_shear <= REST_W'((38'(i_cfg.rest) * 38'(SQRT2_Q16)) >> 16);
                r_spacing    <= REST_W'((38'(i_cfg.rest) * 38'(HOME_SCALE_Q16)) >> 16);
                r_degen      <= 1'b0;
                r_nb         <= '0;
            end
            ST_ROWCOL: begin
                r_row <= div_quot[0][PART_W-1:0];
                r_col <= div_rem[0][PART_W-1:0];
            end
            ST_DRAG: begin
                p_drag      = $signed({1'b0, i_cfg.drag}) * r_vel[r_k];
                r_acc[r_k] <= ACC_W'((-p_drag) >>> 16);
                r_k        <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
            end
            ST_NB: begin
                r_naddr <= AW'(lin);
                if (!inb) begin
                    r_nb <= r_nb + 4'd1;
                end
            end
            ST_DIFF: begin
                for (int k = 0; k < 3; k++) begin
                    r_d[k] <= sat32(ACC_W'(r_pos[k])
                                  - ACC_W'($signed(r_rd_pos[k*DATA_W +: DATA_W])));
                end
                r_sum <= '0;
                r_k   <= '0;
            end
            ST_SQ: begin
                p_sq   = r_d[r_k] * r_d[r_k];
                r_sum <= r_sum + 64'(p_sq);
                r_k   <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
            end
            ST_ROOT: begin
                if (r_sum == '0) begin
                    r_degen <= 1'b1;
                    r_nb    <= r_nb + 4'd1;
                end
            end
            ST_ROOT_WAIT: begin
                r_len <= sqrt_root;
            end
            ST_TENS: begin
                stretch = $signed({12'b0, rest_sel}) - $signed({2'b00, r_len});
                p_tens  = $signed({1'b0, i_cfg.stiffness}) * stretch;
                r_tens <= 44'(p_tens >>> 16);
            end
            ST_ACC: begin
                for (int k = 0; k < 3; k++) begin
                    u = r_d[k][DATA_W-1] ? -$signed({1'b0, div_quot[k]})
                                         : $signed({1'b0, div_quot[k]});
                    p_spr = r_tens * u;
                    r_acc[k] <= r_acc[k] + ACC_W'(p_spr >>> 16);
                end
                r_nb <= r_nb + 4'd1;
            end
            ST_HOME: begin
                r_home_x <= DATA_W'(DATA_W'(r_spacing) * DATA_W'(r_col));
                r_home_z <= DATA_W'(DATA_W'(r_spacing) * DATA_W'(r_row));
            end
            ST_ANCHOR: begin
                if (r_p == i_cfg.anchor) begin
                    for (int k = 0; k < 3; k++) begin
                        home  = (k == 0) ? r_home_x : ((k == 2) ? r_home_z : '0);
                        hdiff = $signed({2'b00, home}) - 34'(r_pos[k]);
                        p_anc = $signed({1'b0, i_cfg.gain}) * hdiff;
                        r_acc[k] <= r_acc[k] + ACC_W'(p_anc >>> 16);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        logic signed [DATA_W-1:0] f;
        logic signed [57:0]       p_acc;
        logic signed [63:0]       a;
        if (out_load) begin
            r_out_p     <= r_p;
            r_out_degen <= r_degen;
            for (int k = 0; k < 3; k++) begin
                f     = sat32(r_acc[k]);
                p_acc = f * $signed({1'b0, i_cfg.inv_mass});
                a     = 64'(p_acc >>> 16);
                if (a > CW_MAX) begin
                    a = CW_MAX;
                end else if (a < CW_MIN) begin
                    a = CW_MIN;
                end
                r_out_dvel[k] <= DATA_W'(a);
                r_out_dpos[k] <= r_vel[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_particle_out = r_out_p;
    assign o_dpos_x       = r_out_dpos[0];
    assign o_dpos_y       = r_out_dpos[1];
    assign o_dpos_z       = r_out_dpos[2];
    assign o_dvel_x       = r_out_dvel[0];
    assign o_dvel_y       = r_out_dvel[1];
    assign o_dvel_z       = r_out_dvel[2];
    assign o_degenerate   = r_out_degen;

endmodule

@@ design/mass_spring_grid_force_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mass_spring_grid_force_eval
// Cloth grid force evaluator: particle loads in, per-particle derivatives out.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (i_in_valid / o_in_stall): op 0 stores a particle's position
//   and velocity and returns nothing; op 1 evaluates a particle and returns
//   one item on the output channel (o_out_valid / i_out_stall).
//   A two-entry queue sits between the input side and the force sequencer.
//   An evaluate holds the sequencer longer for each in-bounds neighbor, up to
//   12, and less for a zero-length one; the per-neighbor cost is set by the
//   32-step square root unit followed by the 17-step divider lanes.
//   Items are handled one at a time in arrival order.
//   A finished result waits in the output register while the sequencer takes
//   the next item; a stall holds the result and the sequencer finishes its
//   next evaluate only once the register is free.
//   Reset empties the queue, drops any pending result and restores register
//   defaults; particle stores are not cleared and must be loaded before use.
//   Registers are APB writable at byte address 4*index, read back the same way.
// ----------------------------------------------------------------------------
module mass_spring_grid_force_eval import msgfe_pkg::*; #(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [4:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_op,
    input  logic [PART_W-1:0]        i_particle,
    input  logic signed [DATA_W-1:0] i_pos_x,
    input  logic signed [DATA_W-1:0] i_pos_y,
    input  logic signed [DATA_W-1:0] i_pos_z,
    input  logic signed [DATA_W-1:0] i_vel_x,
    input  logic signed [DATA_W-1:0] i_vel_y,
    input  logic signed [DATA_W-1:0] i_vel_z,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [PART_W-1:0]        o_particle_out,
    output logic signed [DATA_W-1:0] o_dpos_x,
    output logic signed [DATA_W-1:0] o_dpos_y,
    output logic signed [DATA_W-1:0] o_dpos_z,
    output logic signed [DATA_W-1:0] o_dvel_x,
    output logic signed [DATA_W-1:0] o_dvel_y,
    output logic signed [DATA_W-1:0] o_dvel_z,
    output logic                     o_degenerate
);

    t_cfg  r_cfg;
    t_reg  reg_sel;
    logic  cfg_wr;
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = t_reg'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows      <= 11'd10;
            r_cfg.cols      <= 11'd10;
            r_cfg.inv_mass  <= 25'd65536;
            r_cfg.anchor    <= 10'd50;
            r_cfg.stiffness <= 25'd3276800;
            r_cfg.drag      <= 21'd19661;
            r_cfg.gain      <= 21'd3277;
            r_cfg.rest      <= 21'd13107;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                R_GRID_ROWS:    r_cfg.rows      <= pwdata[10:0];
                R_GRID_COLUMNS: r_cfg.cols      <= pwdata[10:0];
                R_INVERSE_MASS: r_cfg.inv_mass  <= pwdata[24:0];
                R_ANCHOR:       r_cfg.anchor    <= pwdata[9:0];
                R_STIFFNESS:    r_cfg.stiffness <= pwdata[24:0];
                R_DRAG:         r_cfg.drag      <= pwdata[20:0];
                R_ANCHOR_GAIN:  r_cfg.gain      <= pwdata[20:0];
                R_REST_LENGTH:  r_cfg.rest      <= pwdata[20:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            R_GRID_ROWS:    prdata = 32'(r_cfg.rows);
            R_GRID_COLUMNS: prdata = 32'(r_cfg.cols);
            R_INVERSE_MASS: prdata = 32'(r_cfg.inv_mass);
            R_ANCHOR:       prdata = 32'(r_cfg.anchor);
            R_STIFFNESS:    prdata = 32'(r_cfg.stiffness);
            R_DRAG:         prdata = 32'(r_cfg.drag);
            R_ANCHOR_GAIN:  prdata = 32'(r_cfg.gain);
            R_REST_LENGTH:  prdata = 32'(r_cfg.rest);
            default:        prdata = '0;
        endcase
    end

    msgfe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_op       (i_op),
        .i_particle (i_particle),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pos_z    (i_pos_z),
        .i_vel_x    (i_vel_x),
        .i_vel_y    (i_vel_y),
        .i_vel_z    (i_vel_z),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    msgfe_back #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .COORD_WIDTH   (COORD_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_particle_out (o_particle_out),
        .o_dpos_x       (o_dpos_x),
        .o_dpos_y       (o_dpos_y),
        .o_dpos_z       (o_dpos_z),
        .o_dvel_x       (o_dvel_x),
        .o_dvel_y       (o_dvel_y),
        .o_dvel_z       (o_dvel_z),
        .o_degenerate   (o_degenerate)
    );

endmodule

@@ design/msgfe_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msgfe_checker
// Port-level checks of the force evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module msgfe_checker import msgfe_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     psel,
    input logic                     penable,
    input logic                     pwrite,
    input logic                     pready,
    input logic [4:0]               paddr,
    input logic [31:0]              pwdata,
    input logic [31:0]              prdata,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic [PART_W-1:0]        o_particle_out,
    input logic signed [DATA_W-1:0] o_dvel_x
);

    // a held result keeps its particle index and x velocity derivative
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_particle_out)
                                        && $stable(o_dvel_x))
        else $error("result changed while stalled");

    // no result can come out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid ##1 !o_out_valid)
        else $error("result shortly after reset");

    // a written register reads back its low bits
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready) ##1 (paddr == $past(paddr))
        |-> prdata[9:0] == $past(pwdata[9:0]))
        else $error("register readback mismatch");

endmodule

bind mass_spring_grid_force_eval msgfe_checker u_msgfe_checker (.*);
